>>> hw/rtl/cpu_load_percent_monitor_top_defines.svh
// assertion macros used by the back end of the cpu load monitor rtl
`ifndef CPU_LOAD_PERCENT_MONITOR_TOP_DEFINES_SVH
`define CPU_LOAD_PERCENT_MONITOR_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define CLPM_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error("clpm assertion failed");

// next-cycle implication, disabled while reset is asserted
`define CLPM_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error("clpm assertion failed");

`endif

>>> hw/rtl/clpm_pkg.sv
// shared types and constants of the cpu load monitor
package clpm_pkg;

	localparam int WORD_W       = 64;
	localparam int CPU_W        = 3;
	localparam int PCT_W        = 7;
	localparam int PCT_IDX_W    = 3;
	localparam int NUM_CPUS_DEF = 8;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

	localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;
	localparam logic [PCT_IDX_W-1:0] PCT_TOP_BIT = 3'd6;

	typedef enum logic [1:0] {
		K_ZERO = 2'd0,
		K_FULL = 2'd1,
		K_DIV  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [CPU_W-1:0]  cpu;
		kind_t             kind;
		logic [WORD_W-1:0] db;
		logic [WORD_W-1:0] dt;
	} entry_t;

endpackage

>>> hw/rtl/cpu_load_percent_monitor_top.sv
// top level of the per-cpu load percent monitor
// Each accepted word is one sample: a cpu index and six cumulative time counters. One result
// word comes back per sample, in order, carrying the cpu index and the busy share since that
// cpu's previous sample in percent (0 when no time passed, 100 when busy is not below total,
// 0 for a cpu index at or above NUM_CPUS, which leaves the history untouched). The front end
// steps through accept, three adder steps, delta and queue push for each sample, holding at
// the push while the queue is full; the back end skips its loop for a zero or full result and
// otherwise divides with a shift-subtract loop (7 doubling steps plus one add step for each set
// bit of 100). The two overlap through a two-entry queue, so the front end can take a new sample
// while the back end still divides an earlier one. The history is cleared at reset with no extra pass.
module cpu_load_percent_monitor_top #(
	parameter int NUM_CPUS = clpm_pkg::NUM_CPUS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [clpm_pkg::CPU_W-1:0]  cpu_index,
	input  logic [clpm_pkg::WORD_W-1:0] user_time,
	input  logic [clpm_pkg::WORD_W-1:0] system_time,
	input  logic [clpm_pkg::WORD_W-1:0] irq_time,
	input  logic [clpm_pkg::WORD_W-1:0] softirq_time,
	input  logic [clpm_pkg::WORD_W-1:0] idle_time,
	input  logic [clpm_pkg::WORD_W-1:0] iowait_time,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [clpm_pkg::CPU_W-1:0]  load_cpu,
	output logic [clpm_pkg::PCT_W-1:0]  load_percent
);
	import clpm_pkg::*;

	logic   push, queue_full, pop, q_nonempty;
	entry_t push_entry, q_entry;

	clpm_front #(
		.NUM_CPUS(NUM_CPUS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cpu_index    (cpu_index),
		.user_time    (user_time),
		.system_time  (system_time),
		.irq_time     (irq_time),
		.softirq_time (softirq_time),
		.idle_time    (idle_time),
		.iowait_time  (iowait_time),
		.push         (push),
		.push_entry   (push_entry),
		.queue_full   (queue_full)
	);

	clpm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (pop),
		.pop_entry  (q_entry),
		.nonempty   (q_nonempty)
	);

	clpm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_nonempty   (q_nonempty),
		.q_entry      (q_entry),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.load_cpu     (load_cpu),
		.load_percent (load_percent)
	);

endmodule

>>> hw/rtl/clpm_front.sv
// front end: accepts samples, forms sums and deltas, keeps per-cpu history, classifies
module clpm_front #(
	parameter int NUM_CPUS = clpm_pkg::NUM_CPUS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [clpm_pkg::CPU_W-1:0]  cpu_index,
	input  logic [clpm_pkg::WORD_W-1:0] user_time,
	input  logic [clpm_pkg::WORD_W-1:0] system_time,
	input  logic [clpm_pkg::WORD_W-1:0] irq_time,
	input  logic [clpm_pkg::WORD_W-1:0] softirq_time,
	input  logic [clpm_pkg::WORD_W-1:0] idle_time,
	input  logic [clpm_pkg::WORD_W-1:0] iowait_time,
	output logic                        push,
	output clpm_pkg::entry_t            push_entry,
	input  logic                        queue_full
);
	import clpm_pkg::*;

	// only indexes the cpu field can reach need history
	localparam int STORE_DEPTH = (NUM_CPUS < (2 ** CPU_W)) ? NUM_CPUS : (2 ** CPU_W);
	localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	typedef enum logic [5:0] {
		F_IDLE = 6'b000001,
		F_SUM1 = 6'b000010,
		F_SUM2 = 6'b000100,
		F_SUM3 = 6'b001000,
		F_DIFF = 6'b010000,
		F_PUSH = 6'b100000
	} fstate_t;

	fstate_t state_q;

	logic [CPU_W-1:0]  cpu_q;
	logic [WORD_W-1:0] user_q, system_q, irq_q, softirq_q, idle_q, iowait_q;
	logic [WORD_W-1:0] acc0_q, acc1_q, acc2_q;
	logic [WORD_W-1:0] busy_q, total_q;
	logic [WORD_W-1:0] db_q, dt_q;

	logic [WORD_W-1:0] last_busy_q  [STORE_DEPTH];
	logic [WORD_W-1:0] last_total_q [STORE_DEPTH];

	logic                cpu_ok;
	logic [STORE_AW-1:0] idx;
	logic [WORD_W-1:0]   last_busy_rd, last_total_rd;
	kind_t               kind;

	assign cpu_ok        = (32'(cpu_q) < NUM_CPUS);
	assign idx           = cpu_q[STORE_AW-1:0];
	assign last_busy_rd  = cpu_ok ? last_busy_q[idx]  : '0;
	assign last_total_rd = cpu_ok ? last_total_q[idx] : '0;

	always_comb begin
		if (!cpu_ok || (dt_q == '0)) begin
			kind = K_ZERO;
		end else if (db_q >= dt_q) begin
			kind = K_FULL;
		end else begin
			kind = K_DIV;
		end
	end

	assign in_stall        = (state_q != F_IDLE);
	assign push            = (state_q == F_PUSH) && !queue_full;
	assign push_entry.cpu  = cpu_q;
	assign push_entry.kind = kind;
	assign push_entry.db   = db_q;
	assign push_entry.dt   = dt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_valid) state_q <= F_SUM1;
				end
				F_SUM1: state_q <= F_SUM2;
				F_SUM2: state_q <= F_SUM3;
				F_SUM3: state_q <= F_DIFF;
				F_DIFF: state_q <= F_PUSH;
				F_PUSH: begin
					if (!queue_full) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			cpu_q     <= cpu_index;
			user_q    <= user_time;
			system_q  <= system_time;
			irq_q     <= irq_time;
			softirq_q <= softirq_time;
			idle_q    <= idle_time;
			iowait_q  <= iowait_time;
		end
		if (state_q == F_SUM1) begin
			acc0_q <= user_q + system_q;
			acc1_q <= irq_q + softirq_q;
			acc2_q <= idle_q + iowait_q;
		end
		if (state_q == F_SUM2) begin
			busy_q <= acc0_q + acc1_q;
		end
		if (state_q == F_SUM3) begin
			total_q <= busy_q + acc2_q;
		end
		if (state_q == F_DIFF) begin
			db_q <= busy_q - last_busy_rd;
			dt_q <= total_q - last_total_rd;
		end
	end

	// per-cpu history, cleared by reset, written once per sample with an in-range cpu index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_DEPTH; i++) begin
				last_busy_q[i]  <= '0;
				last_total_q[i] <= '0;
			end
		end else if (state_q == F_DIFF && cpu_ok) begin
			last_busy_q[idx]  <= busy_q;
			last_total_q[idx] <= total_q;
		end
	end

endmodule

>>> hw/rtl/clpm_queue.sv
// short fifo between the front end and the divider back end
module clpm_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  clpm_pkg::entry_t push_entry,
	output logic             full,
	input  logic             pop,
	output clpm_pkg::entry_t pop_entry,
	output logic             nonempty
);
	import clpm_pkg::*;

	entry_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full      = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign nonempty  = (count_q != '0);
	assign pop_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_entry;
	end

endmodule

>>> hw/rtl/clpm_back.sv
// back end: shift-subtract percent divider and output register
`include "cpu_load_percent_monitor_top_defines.svh"

module clpm_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_nonempty,
	input  clpm_pkg::entry_t           q_entry,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [clpm_pkg::CPU_W-1:0] load_cpu,
	output logic [clpm_pkg::PCT_W-1:0] load_percent
);
	import clpm_pkg::*;

	typedef enum logic [3:0] {
		B_IDLE = 4'b0001,
		B_DBL  = 4'b0010,
		B_ADD  = 4'b0100,
		B_DONE = 4'b1000
	} bstate_t;

	bstate_t state_q;

	logic [CPU_W-1:0]     cpu_q;
	kind_t                kind_q;
	logic [WORD_W-1:0]    db_q, dt_q, r_q;
	logic [PCT_W-1:0]     q_q;
	logic [PCT_IDX_W-1:0] bit_q;

	logic             out_valid_q;
	logic [CPU_W-1:0] load_cpu_q;
	logic [PCT_W-1:0] load_percent_q;

	logic [WORD_W:0] dbl, dbl_sub, add, add_sub;
	logic            dbl_ge, add_ge, out_free;

	// remainder stays below the divisor, so both steps need one conditional subtract
	assign dbl     = {r_q, 1'b0};
	assign dbl_sub = dbl - {1'b0, dt_q};
	assign dbl_ge  = (dbl >= {1'b0, dt_q});
	assign add     = {1'b0, r_q} + {1'b0, db_q};
	assign add_sub = add - {1'b0, dt_q};
	assign add_ge  = (add >= {1'b0, dt_q});

	assign out_free = !out_valid_q || !out_stall;
	assign pop      = (state_q == B_IDLE) && q_nonempty;

	assign out_valid    = out_valid_q;
	assign load_cpu     = load_cpu_q;
	assign load_percent = load_percent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (q_nonempty) state_q <= (q_entry.kind == K_DIV) ? B_DBL : B_DONE;
				end
				B_DBL: begin
					if (PCT_SCALE[bit_q]) begin
						state_q <= B_ADD;
					end else if (bit_q == '0) begin
						state_q <= B_DONE;
					end
				end
				B_ADD: state_q <= (bit_q == '0) ? B_DONE : B_DBL;
				B_DONE: begin
					if (out_free) state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
			if (state_q == B_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (q_nonempty) begin
					cpu_q  <= q_entry.cpu;
					kind_q <= q_entry.kind;
					db_q   <= q_entry.db;
					dt_q   <= q_entry.dt;
					r_q    <= '0;
					bit_q  <= PCT_TOP_BIT;
					case (q_entry.kind)
						K_FULL:  q_q <= PCT_SCALE;
						default: q_q <= '0;
					endcase
				end
			end
			B_DBL: begin
				q_q <= {q_q[PCT_W-2:0], dbl_ge};
				r_q <= dbl_ge ? dbl_sub[WORD_W-1:0] : dbl[WORD_W-1:0];
				if (!PCT_SCALE[bit_q] && bit_q != '0) bit_q <= bit_q - 1'b1;
			end
			B_ADD: begin
				q_q <= q_q + PCT_W'(add_ge);
				r_q <= add_ge ? add_sub[WORD_W-1:0] : add[WORD_W-1:0];
				if (bit_q != '0) bit_q <= bit_q - 1'b1;
			end
			B_DONE: begin
				if (out_free) begin
					load_cpu_q     <= cpu_q;
					load_percent_q <= q_q;
				end
			end
			default: ;
		endcase
	end

	`CLPM_ASSERT_IMPL(a_rem_below_div, clk, arst_n,
		(state_q == B_DBL || state_q == B_ADD), (r_q < dt_q))
	`CLPM_ASSERT_IMPL(a_div_quot_range, clk, arst_n,
		(state_q == B_DONE && kind_q == K_DIV), (q_q < PCT_SCALE))
	`CLPM_ASSERT_IMPL(a_out_pct_range, clk, arst_n,
		out_valid_q, (load_percent_q <= PCT_SCALE))
	`CLPM_ASSERT_NEXT(a_pop_leaves_idle, clk, arst_n,
		(state_q == B_IDLE && q_nonempty), (state_q != B_IDLE))

endmodule
